// File: design/hslp_pkg.sv
package hslp_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned LEN_W           = 8;
  localparam int unsigned RLEN_W          = 16;
  localparam int unsigned CFG_IDX_W       = 8;
  localparam int unsigned NUM_CFG         = 4;

  localparam logic [RLEN_W-1:0] RLEN_MAX = '1;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_DONE       = 3'd1;
  localparam logic [2:0] ST_INVALID    = 3'd2;
  localparam logic [2:0] ST_TOO_LONG   = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;
  localparam logic [2:0] ST_DISCARD    = 3'd5;

  localparam logic [2:0] PH_PROTOCOL = 3'd0;
  localparam logic [2:0] PH_VERSION  = 3'd1;
  localparam logic [2:0] PH_STATUS   = 3'd2;
  localparam logic [2:0] PH_REASON   = 3'd3;
  localparam logic [2:0] PH_LF       = 3'd4;

  localparam logic [1:0] FID_PROTOCOL = 2'd0;
  localparam logic [1:0] FID_REASON   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MAX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION_MAX  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_MAX   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REASON_MAX   = 8'd3;

  localparam logic [LEN_W-1:0] PROTOCOL_MAX_RST = 8'd16;
  localparam logic [LEN_W-1:0] VERSION_MAX_RST  = 8'd16;
  localparam logic [LEN_W-1:0] STATUS_MAX_RST   = 8'd8;
  localparam logic [LEN_W-1:0] REASON_MAX_RST   = 8'd128;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        field_id;
    logic [7:0]        data_byte;
    logic              data_valid;
    logic              field_end;
    logic [2:0]        parse_status;
    logic [RLEN_W-1:0] read_length;
  } out_word_t;

endpackage

// File: design/http_status_line_parser.sv
// http status line parser, one byte per word
//
// input channel (in_valid_i / in_ready_o / in_data_i): one byte of the
// status line per word, with end_of_buffer marking the last byte held.
// output channel (out_valid_o / out_ready_i / out_data_o): exactly one
// result word per input word, in order: field id, stored data byte,
// field end flag, parse status and the line length on line done.
// config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
// always ready; indexes 0..3 set the protocol, version, status and reason
// length limits, other indexes are dropped. write only while idle.
// the result is registered and valid in the cycle after input accept.
// throughput is one word per cycle while the receiver does not stall: the
// per-byte state update and the result register form a single stage, and
// the next byte is taken in the same cycle the held result is taken.
// when the receiver stalls, the result register holds its word and
// in_ready_o drops until out_ready_i returns.
// reset empties the result register, returns the parser to the protocol
// field with zero counts, leaves discard mode and loads the default limits.
module http_status_line_parser
  import hslp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i
);

  localparam int unsigned ExtW = (COUNT_WIDTH > RLEN_W) ? COUNT_WIDTH : RLEN_W;
  localparam logic [ExtW-1:0] RlenMaxExt = ExtW'(RLEN_MAX);

  logic [LEN_W-1:0]       cfg_max_q [NUM_CFG];
  logic [2:0]             phase_q, phase_d;
  logic [LEN_W-1:0]       flen_q, flen_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic [ExtW-1:0]        cnt_ext;
  logic                   disc_q, disc_d;
  logic                   out_valid_q;
  out_word_t              out_data_q;
  out_word_t              res;
  logic                   in_acc;
  logic                   last;
  logic [7:0]             b;
  logic                   is_end, bad;
  logic [LEN_W-1:0]       lim;
  logic [2:0]             status;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign b    = in_data_i.in_byte;
  assign last = in_data_i.end_of_buffer;

  always_comb begin
    res     = '0;
    phase_d = phase_q;
    flen_d  = flen_q;
    cnt_d   = cnt_q;
    disc_d  = disc_q;
    is_end  = 1'b0;
    bad     = 1'b0;
    status  = ST_BUSY;
    lim     = cfg_max_q[phase_q[1:0]];
    cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
    cnt_ext = ExtW'(cnt_inc);
    if (disc_q) begin
      status = ST_DISCARD;
      if (last) begin
        disc_d  = 1'b0;
        phase_d = PH_PROTOCOL;
        flen_d  = '0;
        cnt_d   = '0;
      end
    end else begin
      cnt_d = cnt_inc;
      if (phase_q <= PH_REASON) begin
        res.field_id = phase_q[1:0];
        case (phase_q)
          PH_PROTOCOL: begin
            is_end = (b == CH_SLASH);
            bad    = (b == CH_SP) || (b == CH_CR) || (b == CH_LF);
          end
          PH_REASON: begin
            is_end = (b == CH_CR);
            bad    = 1'b0;
          end
          default: begin
            is_end = (b == CH_SP);
            bad    = (b == CH_SLASH) || (b == CH_CR) || (b == CH_LF);
          end
        endcase
        if (is_end) begin
          res.field_end = 1'b1;
          phase_d       = phase_q + 3'd1;
          flen_d        = '0;
        end else if (bad) begin
          status = ST_INVALID;
        end else if (flen_q >= lim) begin
          status = ST_TOO_LONG;
        end else begin
          res.data_valid = 1'b1;
          res.data_byte  = b;
          flen_d         = flen_q + LEN_W'(1);
        end
      end else begin
        res.field_id = FID_REASON;
        if (b == CH_LF) begin
          status          = ST_DONE;
          res.read_length = (cnt_ext > RlenMaxExt) ? RLEN_MAX : cnt_ext[RLEN_W-1:0];
        end else begin
          status = ST_INVALID;
        end
      end

      if (status == ST_DONE) begin
        phase_d = PH_PROTOCOL;
        flen_d  = '0;
        cnt_d   = '0;
      end else if (status == ST_INVALID || status == ST_TOO_LONG) begin
        phase_d = PH_PROTOCOL;
        flen_d  = '0;
        cnt_d   = '0;
        disc_d  = !last;
      end else if (last) begin
        status  = ST_INCOMPLETE;
        phase_d = PH_PROTOCOL;
        flen_d  = '0;
        cnt_d   = '0;
      end
    end
    res.parse_status = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PROTOCOL;
      flen_q      <= '0;
      cnt_q       <= '0;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        flen_q  <= flen_d;
        cnt_q   <= cnt_d;
        disc_q  <= disc_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_max_q[0] <= PROTOCOL_MAX_RST;
      cfg_max_q[1] <= VERSION_MAX_RST;
      cfg_max_q[2] <= STATUS_MAX_RST;
      cfg_max_q[3] <= REASON_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PROTOCOL_MAX: cfg_max_q[0] <= cfg_data_i;
        REG_VERSION_MAX:  cfg_max_q[1] <= cfg_data_i;
        REG_STATUS_MAX:   cfg_max_q[2] <= cfg_data_i;
        REG_REASON_MAX:   cfg_max_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// File: design/hslp_checker.sv
module hslp_checker
  import hslp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // every accepted byte yields a result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result one cycle after accept");

  a_rlen_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.read_length != '0) |->
      out_data_o.parse_status == ST_DONE)
    else $error("read_length set without line done");

  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.data_valid || out_data_o.field_end) |->
      (out_data_o.parse_status == ST_BUSY ||
       out_data_o.parse_status == ST_INCOMPLETE) &&
      !(out_data_o.data_valid && out_data_o.field_end))
    else $error("data or field end with bad status");

  a_discard_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.parse_status == ST_DISCARD |->
      !out_data_o.data_valid && !out_data_o.field_end &&
      out_data_o.field_id == FID_PROTOCOL)
    else $error("discarded byte reported as field data");

endmodule

bind http_status_line_parser hslp_checker u_hslp_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import hslp_pkg::*;

  localparam int N_PHASES        = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int WDOG_LIMIT      = 500;

  typedef enum logic [1:0] {FLT_NONE, FLT_DELIM, FLT_LONG, FLT_NO_LF} flt_e;
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_word_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_word_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [LEN_W-1:0]     cfg_data_i  = '0;

  http_status_line_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // parser mirror
  logic [LEN_W-1:0]           lim_q [NUM_CFG] = '{PROTOCOL_MAX_RST, VERSION_MAX_RST,
                                                  STATUS_MAX_RST, REASON_MAX_RST};
  logic [2:0]                 phase_q   = PH_PROTOCOL;
  logic [LEN_W-1:0]           fld_len   = '0;
  logic [COUNT_WIDTH_DEF-1:0] line_cnt  = '0;
  logic                       discard_q = 1'b0;

  in_word_t   byte_q [$];
  out_word_t  parsed_q [$];
  logic [7:0] line_buf [$];
  int         gen_lim [NUM_CFG] = '{PROTOCOL_MAX_RST, VERSION_MAX_RST,
                                    STATUS_MAX_RST, REASON_MAX_RST};

  int n_gen = 0;
  int n_err = 0;
  int n_done = 0;
  int n_fault = 0;
  int n_short = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  logic [7:0] rx_tick = '0;
  rx_mode_e   rx_mode = RX_FREE;
  out_word_t  head_word;

  function automatic void clear_line();
    phase_q  = PH_PROTOCOL;
    fld_len  = '0;
    line_cnt = '0;
  endfunction

  function automatic out_word_t parse_byte(in_word_t w);
    out_word_t  r;
    logic       is_end;
    logic       bad;
    logic [7:0] b;
    r = '0;
    b = w.in_byte;
    r.parse_status = ST_BUSY;
    if (discard_q) begin
      r.parse_status = ST_DISCARD;
      if (w.end_of_buffer) begin
        discard_q = 1'b0;
        clear_line();
      end
    end else begin
      if (line_cnt != '1) line_cnt = line_cnt + COUNT_WIDTH_DEF'(1);
      if (phase_q <= PH_REASON) begin
        r.field_id = phase_q[1:0];
        case (phase_q)
          PH_PROTOCOL: begin
            is_end = (b == CH_SLASH);
            bad    = (b == CH_SP || b == CH_CR || b == CH_LF);
          end
          PH_REASON: begin
            is_end = (b == CH_CR);
            bad    = 1'b0;
          end
          default: begin
            is_end = (b == CH_SP);
            bad    = (b == CH_SLASH || b == CH_CR || b == CH_LF);
          end
        endcase
        if (is_end) begin
          r.field_end = 1'b1;
          phase_q     = phase_q + 3'd1;
          fld_len     = '0;
        end else if (bad) begin
          r.parse_status = ST_INVALID;
        end else if (fld_len >= lim_q[phase_q[1:0]]) begin
          r.parse_status = ST_TOO_LONG;
        end else begin
          r.data_valid = 1'b1;
          r.data_byte  = b;
          fld_len      = fld_len + LEN_W'(1);
        end
      end else begin
        r.field_id = FID_REASON;
        if (b == CH_LF) begin
          r.parse_status = ST_DONE;
          r.read_length  = (line_cnt > RLEN_MAX) ? RLEN_MAX : RLEN_W'(line_cnt);
        end else begin
          r.parse_status = ST_INVALID;
        end
      end
      if (r.parse_status == ST_DONE) begin
        clear_line();
      end else if (r.parse_status == ST_INVALID || r.parse_status == ST_TOO_LONG) begin
        clear_line();
        discard_q = !w.end_of_buffer;
      end else if (w.end_of_buffer) begin
        r.parse_status = ST_INCOMPLETE;
        clear_line();
      end
    end
    return r;
  endfunction

  function automatic void cmp(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      n_err++;
    end
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_data_i  <= byte_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 8'd1;
      if (rx_left == 0) begin
        rx_left <= $urandom_range(30, 200);
        case ($urandom_range(0, 3))
          0:       rx_mode <= RX_FREE;
          1:       rx_mode <= RX_COIN;
          2:       rx_mode <= RX_PERIODIC;
          default: rx_mode <= RX_BURSTY;
        endcase
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FREE:     out_ready_i <= 1'b1;
        RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_ready_i <= (rx_tick[1:0] != 2'b11);
        default: begin
          if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // accepted words: limit writes and byte predictions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < NUM_CFG)
        lim_q[cfg_index_i[1:0]] = cfg_data_i;
      if (in_valid_i && in_ready_o)
        parsed_q.push_back(parse_byte(in_data_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parsed_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %p", $time, out_data_o);
        n_err++;
      end else begin
        head_word = parsed_q.pop_front();
        cmp("field_id", head_word.field_id, out_data_o.field_id);
        cmp("data_byte", head_word.data_byte, out_data_o.data_byte);
        cmp("data_valid", head_word.data_valid, out_data_o.data_valid);
        cmp("field_end", head_word.field_end, out_data_o.field_end);
        cmp("parse_status", head_word.parse_status, out_data_o.parse_status);
        cmp("read_length", head_word.read_length, out_data_o.read_length);
      end
      case (out_data_o.parse_status)
        ST_DONE:                 n_done++;
        ST_INVALID, ST_TOO_LONG: n_fault++;
        ST_INCOMPLETE:           n_short++;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("FAIL http_status_line_parser");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic flush_buffer();
    in_word_t w;
    foreach (line_buf[i]) begin
      w.in_byte       = line_buf[i];
      w.end_of_buffer = (i == line_buf.size() - 1);
      byte_q.push_back(w);
    end
    n_gen += line_buf.size();
    line_buf.delete();
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || in_valid_i || out_valid_o || parsed_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < NUM_CFG) gen_lim[idx[1:0]] = val;
  endtask

  task automatic set_limits(int p, int v, int s, int r);
    write_reg(REG_PROTOCOL_MAX, LEN_W'(p));
    write_reg(REG_VERSION_MAX, LEN_W'(v));
    write_reg(REG_STATUS_MAX, LEN_W'(s));
    write_reg(REG_REASON_MAX, LEN_W'(r));
  endtask

  function automatic int rand_lim();
    return ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 12);
  endfunction

  // one buffer: a few lines, some broken, sometimes cut short, or plain noise
  task automatic add_buffer();
    int         n;
    int         cut;
    int         bad_f;
    int         bad_at;
    int         long_f;
    int         lim;
    flt_e       fault;
    logic [7:0] c;
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        c = 8'($urandom_range(0, 255));
        line_buf.push_back(c);
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0:       fault = FLT_DELIM;
          1:       fault = FLT_LONG;
          2:       fault = FLT_NO_LF;
          default: fault = FLT_NONE;
        endcase
        bad_f  = $urandom_range(0, 2);
        long_f = $urandom_range(0, 3);
        for (int f = 0; f < NUM_CFG; f++) begin
          lim = gen_lim[f];
          if (fault == FLT_LONG && f == long_f) n = lim + 1;
          else if ($urandom_range(0, 11) == 0) n = lim;
          else n = $urandom_range(0, (lim < 5) ? lim : 5);
          bad_at = $urandom_range(0, n);
          for (int i = 0; i <= n; i++) begin
            if (fault == FLT_DELIM && f == bad_f && i == bad_at) begin
              case ($urandom_range(0, 2))
                0:       c = CH_CR;
                1:       c = CH_LF;
                default: c = (f == PH_PROTOCOL) ? CH_SP : CH_SLASH;
              endcase
              line_buf.push_back(c);
            end
            if (i < n) begin
              if (f == PH_REASON && $urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 2))
                  0:       c = CH_SP;
                  1:       c = CH_SLASH;
                  default: c = CH_LF;
                endcase
              end else begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_CR ||
                       (f != PH_REASON && (c == CH_SLASH || c == CH_SP || c == CH_LF)));
              end
              line_buf.push_back(c);
            end
          end
          line_buf.push_back((f == PH_PROTOCOL) ? CH_SLASH : (f == PH_REASON) ? CH_CR : CH_SP);
        end
        if (fault == FLT_NO_LF) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_LF);
        end else begin
          c = CH_LF;
        end
        line_buf.push_back(c);
      end
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, line_buf.size());
        while (line_buf.size() > cut) void'(line_buf.pop_back());
      end
    end
    flush_buffer();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1:            set_limits(1, 1, 1, 1);
          2:            set_limits(255, 255, 255, 255);
          3:            set_limits(3, 2, 0, 5);
          N_PHASES - 1: set_limits(1, 255, 255, 1);
          default:      set_limits(rand_lim(), rand_lim(), rand_lim(), rand_lim());
        endcase
        // index outside the register map is dropped
        if (ph == 5) write_reg(8'hFC, 8'hA5);
      end
      @(negedge clk_i);
      if (ph == 0) begin
        // reason holding slash, lf and space; lf carries the buffer end
        line_buf = '{8'hFF, CH_SLASH, 8'h00, CH_SP, 8'h32, CH_SP,
                     CH_SLASH, CH_LF, CH_SP, CH_CR, CH_LF};
        flush_buffer();
        // bad delimiter on the first byte, then discard to the end mark
        line_buf = '{CH_SP, 8'h78, 8'h79};
        flush_buffer();
        // empty fields, cr not followed by lf on the last byte
        line_buf = '{CH_SLASH, CH_SP, CH_SP, CH_CR, 8'h5A};
        flush_buffer();
        // buffer ends mid line
        line_buf = '{8'h51};
        flush_buffer();
      end else if (ph == 1) begin
        // second protocol byte over the limit of one
        line_buf = '{8'h61, 8'h62, 8'h63};
        flush_buffer();
      end
      while (n_gen < (ph + 1) * ITEMS_PER_PHASE) add_buffer();
    end
    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("sent %0d bytes under %0d limit settings, with bursts and receiver stalls",
             n_gen, N_PHASES);
    $display("seen %0d lines done, %0d field errors, %0d cut buffers, %0d mismatches",
             n_done, n_fault, n_short, n_err);
    if (n_err == 0) begin
      $display("PASS http_status_line_parser");
    end else begin
      $display("FAIL http_status_line_parser");
    end
    $finish;
  end

endmodule

// File: files.f
design/hslp_pkg.sv
design/http_status_line_parser.sv
design/hslp_checker.sv
tb/sv/tb.sv
